// File: src/appc_pkg.sv
`default_nettype none

package appc_pkg;

   // Window and stream geometry.
   localparam int WIN_LEN      = 15;
   localparam int FILL_W       = $clog2(WIN_LEN + 1);
   localparam int BYTE_W       = 8;
   localparam int POS_W        = 6;
   localparam int HEADER_BYTES = 36;
   localparam int CHECK_OFFSET = 9;
   localparam int PATCH_FIRST  = 9;

   // Configuration register widths.
   localparam int DEV_W       = 5;
   localparam int FUNC_W      = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   // Result packing.
   localparam int STATUS_W    = 2;
   localparam int RSP_FIELD_W = 2 * BYTE_W + STATUS_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Path text that is rewritten; the first character sits in the top byte.
   localparam logic [WIN_LEN*BYTE_W-1:0] PATH_PATTERN = "/0000:00:ff.ff/";
   localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2e;
   localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2f;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SHORT     = 2'd1,
      STATUS_NO_DEVICE = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEVICE_NUMBER   = 2'd0,
      CSR_FUNCTION_NUMBER = 2'd1,
      CSR_DEVICE_KNOWN    = 2'd2
   } csr_index_type;

   // One byte on its way from the window to the result stage.
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              known;
   } entry_type;

   function automatic logic [BYTE_W-1:0] pattern_byte(input logic [FILL_W-1:0] idx);
      logic [WIN_LEN*BYTE_W-1:0] shifted;
      shifted = PATH_PATTERN >> ((WIN_LEN - 1 - int'(idx)) * BYTE_W);
      return shifted[BYTE_W-1:0];
   endfunction

   // Lower-case hex character for one nibble.
   function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] v);
      logic [BYTE_W-1:0] result;
      if (v < 4'd10) begin
         result = 8'h30 + {4'h0, v};
      end else begin
         result = 8'h57 + {4'h0, v};
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// File: src/acpi_pci_path_patch_checksum_top.sv
// ACPI table path patcher with checksum recompute.
// Table bytes enter on the req_ stream, one item per byte, req_tlast on the final one.
// Patched bytes leave on the rsp_ stream in the same order, one item per byte.
// Each byte is held in a 15-byte window; it leaves when 14 newer bytes have arrived,
// so once the window is full the stream runs at one byte per cycle unless the queue
// is full. A leaving byte passes the queue and then the output register to reach rsp_.
// After the final byte the window drains up to 15 bytes, one per cycle unless the queue
// is full; req_tready stays low until the last byte has entered the queue.
// The byte at the checksum offset is sent as zero; the final item carries the
// value for that offset and a status code in its tdata.
// The csr_ port writes the boot device and function numbers and the device-known flag;
// the user must write it only while no table is in flight; the block does not enforce it.
// Reset is synchronous; it empties the window, queue and output register and sets
// the device to 0, the function to 0 and device-known to 1.
// When rsp_tready is low the output register holds its item, the queue fills, and
// req_tready drops once the queue is full; nothing is lost.

`default_nettype none

module acpi_pci_path_patch_checksum_top #(
   parameter int QUEUE_DEPTH = appc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Input stream.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [appc_pkg::BYTE_W-1:0]       req_tdata,   // [7:0] table_byte
   input  wire logic                              req_tlast,   // table_end
   // Result stream.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [appc_pkg::RSP_TDATA_W-1:0]       rsp_tdata,   // [7:0] out_byte,
                                                               // [15:8] fill_value,
                                                               // [17:16] status, rest zero
   output logic                                   rsp_tlast,   // out_last
   // Configuration writes.
   input  wire logic                              csr_we,
   input  wire logic [appc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [appc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import appc_pkg::*;

   logic [DEV_W-1:0]  device_number_ff;
   logic [FUNC_W-1:0] function_number_ff;
   logic              device_known_ff;

   logic              push_valid;
   entry_type         push_entry;
   logic              q_full;
   logic              head_valid;
   entry_type         head_entry;
   logic              pop;

   logic [BYTE_W-1:0] rsp_byte;
   logic [BYTE_W-1:0] rsp_fill;
   status_type        rsp_status;

   // Configuration registers; writes to an unused index are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         device_number_ff   <= '0;
         function_number_ff <= '0;
         device_known_ff    <= 1'b1;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DEVICE_NUMBER: begin
               device_number_ff <= csr_wdata[DEV_W-1:0];
            end
            CSR_FUNCTION_NUMBER: begin
               function_number_ff <= csr_wdata[FUNC_W-1:0];
            end
            CSR_DEVICE_KNOWN: begin
               device_known_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Front: window, path match and patch.
   appc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_data        (req_tdata),
      .req_end         (req_tlast),
      .device_number   (device_number_ff),
      .function_number (function_number_ff),
      .device_known    (device_known_ff),
      .push_valid      (push_valid),
      .push_entry      (push_entry),
      .q_full          (q_full)
   );

   // Short queue decoupling the window from the output side.
   appc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (q_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   // Back: checksum offset zeroing, byte sum and final status.
   appc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_byte   (rsp_byte),
      .rsp_last   (rsp_tlast),
      .rsp_fill   (rsp_fill),
      .rsp_status (rsp_status)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - RSP_FIELD_W){1'b0}}, rsp_status, rsp_fill, rsp_byte};

endmodule

`default_nettype wire

// File: src/appc_front.sv
`default_nettype none

module appc_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [appc_pkg::BYTE_W-1:0]   req_data,
   input  wire logic                          req_end,
   input  wire logic [appc_pkg::DEV_W-1:0]    device_number,
   input  wire logic [appc_pkg::FUNC_W-1:0]   function_number,
   input  wire logic                          device_known,
   output logic                               push_valid,
   output appc_pkg::entry_type                push_entry,
   input  wire logic                          q_full
);
   import appc_pkg::*;

   logic [BYTE_W-1:0] win_ff [WIN_LEN];
   logic [BYTE_W-1:0] win_in [WIN_LEN];
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              flush_ff, flush_in;
   logic              known_ff, known_in;

   logic [BYTE_W-1:0] cand [WIN_LEN];
   logic [BYTE_W-1:0] patched [WIN_LEN];
   logic              accept;
   logic              window_full;
   logic              pattern_hit;
   logic              do_patch;

   assign req_ready = !flush_ff && !q_full;
   assign accept    = req_valid && req_ready;
   assign window_full = (fill_ff == FILL_W'(WIN_LEN - 1));

   // Window with the incoming byte placed behind the stored ones.
   always_comb begin
      for (int i = 0; i < WIN_LEN; i++) begin
         cand[i] = (fill_ff == FILL_W'(i)) ? req_data : win_ff[i];
      end
   end

   always_comb begin
      pattern_hit = 1'b1;
      for (int i = 0; i < WIN_LEN; i++) begin
         if (cand[i] != pattern_byte(FILL_W'(i))) begin
            pattern_hit = 1'b0;
         end
      end
   end

   assign do_patch = device_known && (pos_ff >= POS_W'(HEADER_BYTES)) && pattern_hit;

   always_comb begin
      for (int i = 0; i < WIN_LEN; i++) begin
         patched[i] = cand[i];
      end
      if (do_patch) begin
         patched[PATCH_FIRST]     = hex_digit({3'b000, device_number[DEV_W-1]});
         patched[PATCH_FIRST + 1] = hex_digit(device_number[3:0]);
         patched[PATCH_FIRST + 2] = CHAR_DOT;
         patched[PATCH_FIRST + 3] = hex_digit({1'b0, function_number});
         patched[PATCH_FIRST + 4] = CHAR_SLASH;
      end
   end

   always_comb begin
      for (int i = 0; i < WIN_LEN; i++) begin
         win_in[i] = win_ff[i];
      end
      fill_in          = fill_ff;
      pos_in           = pos_ff;
      flush_in         = flush_ff;
      known_in         = known_ff;
      push_valid       = 1'b0;
      push_entry.data  = win_ff[0];
      push_entry.last  = 1'b0;
      push_entry.known = known_ff;

      if (flush_ff) begin
         // Drain the window one byte per cycle after the final byte, while the queue has room.
         if (!q_full) begin
            push_valid      = 1'b1;
            push_entry.last = (fill_ff == FILL_W'(1));
            for (int i = 0; i < WIN_LEN - 1; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            fill_in = fill_ff - FILL_W'(1);
            if (fill_ff == FILL_W'(1)) begin
               flush_in = 1'b0;
               pos_in   = '0;
            end
         end
      end else if (accept) begin
         if (req_end) begin
            for (int i = 0; i < WIN_LEN; i++) begin
               win_in[i] = cand[i];
            end
            fill_in  = fill_ff + FILL_W'(1);
            flush_in = 1'b1;
            known_in = device_known;
         end else if (window_full) begin
            // Window complete: release the oldest byte, possibly patched.
            push_valid       = 1'b1;
            push_entry.data  = patched[0];
            push_entry.known = device_known;
            for (int i = 0; i < WIN_LEN - 1; i++) begin
               win_in[i] = patched[i + 1];
            end
            if (pos_ff != {POS_W{1'b1}}) begin
               pos_in = pos_ff + POS_W'(1);
            end
         end else begin
            for (int i = 0; i < WIN_LEN; i++) begin
               win_in[i] = cand[i];
            end
            fill_in = fill_ff + FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WIN_LEN; i++) begin
         win_ff[i] <= win_in[i];
      end
      if (reset) begin
         fill_ff  <= '0;
         pos_ff   <= '0;
         flush_ff <= 1'b0;
         known_ff <= 1'b1;
      end else begin
         fill_ff  <= fill_in;
         pos_ff   <= pos_in;
         flush_ff <= flush_in;
         known_ff <= known_in;
      end
   end

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !q_full)
      else $error("front pushed into a full queue");

   a_last_empties_window: assert property (@(posedge clock) disable iff (reset)
      push_valid && push_entry.last |=> fill_ff == '0 && !flush_ff)
      else $error("window not empty after the final byte left");

endmodule

`default_nettype wire

// File: src/appc_queue.sv
`default_nettype none

module appc_queue #(
   parameter int DEPTH = appc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  wire appc_pkg::entry_type  push_entry,
   output logic                      full,
   output logic                      head_valid,
   output appc_pkg::entry_type       head_entry,
   input  wire logic                 pop
);
   import appc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type         mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond its depth");

endmodule

`default_nettype wire

// File: src/appc_back.sv
`default_nettype none

module appc_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          head_valid,
   input  wire appc_pkg::entry_type           head_entry,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [appc_pkg::BYTE_W-1:0]        rsp_byte,
   output logic                               rsp_last,
   output logic [appc_pkg::BYTE_W-1:0]        rsp_fill,
   output appc_pkg::status_type               rsp_status
);
   import appc_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] saved_ff, saved_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              last_ff, last_in;
   logic [BYTE_W-1:0] fill_ff, fill_in;
   status_type        status_ff, status_in;

   logic              at_check;
   logic [BYTE_W-1:0] sent_byte;
   logic [BYTE_W-1:0] sum_next;
   logic [BYTE_W-1:0] saved_next;
   logic              too_short;

   assign pop = head_valid && (!valid_ff || rsp_ready);

   assign at_check   = (pos_ff == POS_W'(CHECK_OFFSET));
   assign sent_byte  = at_check ? '0 : head_entry.data;
   assign saved_next = at_check ? head_entry.data : saved_ff;
   assign sum_next   = sum_ff + sent_byte;
   // Table length is the bytes sent before this one plus this one.
   assign too_short  = (({1'b0, pos_ff} + (POS_W + 1)'(1)) < (POS_W + 1)'(HEADER_BYTES));

   always_comb begin
      pos_in    = pos_ff;
      sum_in    = sum_ff;
      saved_in  = saved_ff;
      valid_in  = valid_ff && !rsp_ready;
      byte_in   = byte_ff;
      last_in   = last_ff;
      fill_in   = fill_ff;
      status_in = status_ff;
      if (pop) begin
         valid_in  = 1'b1;
         byte_in   = sent_byte;
         last_in   = head_entry.last;
         fill_in   = '0;
         status_in = STATUS_OK;
         if (head_entry.last) begin
            if (too_short) begin
               fill_in   = saved_next;
               status_in = STATUS_SHORT;
            end else if (!head_entry.known) begin
               fill_in   = saved_next;
               status_in = STATUS_NO_DEVICE;
            end else begin
               fill_in = BYTE_W'(8'd0 - sum_next);
            end
            pos_in   = '0;
            sum_in   = '0;
            saved_in = '0;
         end else begin
            sum_in   = sum_next;
            saved_in = saved_next;
            if (pos_ff != {POS_W{1'b1}}) begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      fill_ff   <= fill_in;
      status_ff <= status_in;
      if (reset) begin
         pos_ff   <= '0;
         sum_ff   <= '0;
         saved_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         saved_ff <= saved_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_byte   = byte_ff;
   assign rsp_last   = last_ff;
   assign rsp_fill   = fill_ff;
   assign rsp_status = status_ff;

   a_summary_only_on_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !last_ff |-> status_ff == STATUS_OK && fill_ff == '0)
      else $error("checksum fields set on a byte that is not final");

endmodule

`default_nettype wire
